// ----- rtl/stt_pkg.sv -----
// Shared types, constants and character helpers for the source text tokenizer.
// No dependencies; every other file in rtl refers to this package by scoped names.
package stt_pkg;

  localparam int OffsetBitsDef = 16;
  localparam int QueueDepth    = 4;
  localparam int MaxTokens     = 3;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSemi   = 8'h3B;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharUnder  = 8'h5F;

  typedef enum logic [3:0] {
    TkEof      = 4'd0,
    TkLParen   = 4'd1,
    TkRParen   = 4'd2,
    TkIdent    = 4'd3,
    TkInteger  = 4'd4,
    TkVar      = 4'd5,
    TkFunction = 4'd6,
    TkReturn   = 4'd7,
    TkError    = 4'd8
  } tok_kind_e;

  typedef enum logic [4:0] {
    ModeIdle    = 5'b00001,
    ModeIdent   = 5'b00010,
    ModeInt     = 5'b00100,
    ModeComment = 5'b01000,
    ModeError   = 5'b10000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
  } tok_t;

  // Tokens caused by one character, slot 0 first
  typedef struct packed {
    logic [1:0]                cnt;
    tok_t [MaxTokens-1:0]      tok;
  } bundle_t;

  typedef struct packed {
    logic [2:0] cand;
    logic [3:0] idx;
  } kw_state_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CharUnder;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CharSpace || c == CharTab || c == CharLf || c == CharCr;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
    logic [63:0] text;
    text = (k == 2'd0) ? {"var", 40'h0} : (k == 2'd1) ? "function" : {"return", 16'h0};
    return text[63 - 8*i -: 8];
  endfunction

  function automatic logic [3:0] kw_len(logic [1:0] k);
    return (k == 2'd0) ? 4'd3 : (k == 2'd1) ? 4'd8 : 4'd6;
  endfunction

  // Narrow the keyword candidates by one more identifier character
  function automatic kw_state_t kw_advance(kw_state_t s, logic [7:0] c);
    kw_state_t r;
    r.cand = 3'b000;
    for (int k = 0; k < 3; k++) begin
      if (s.cand[k] && s.idx < kw_len(2'(k)) && kw_char(2'(k), s.idx[2:0]) == c) begin
        r.cand[k] = 1'b1;
      end
    end
    r.idx = (s.idx == 4'hF) ? s.idx : s.idx + 4'd1;
    return r;
  endfunction

  function automatic logic [3:0] ident_kind(kw_state_t s);
    logic [3:0] kind;
    kind = TkIdent;
    for (int k = 2; k >= 0; k--) begin
      if (s.cand[k] && s.idx == kw_len(2'(k))) begin
        kind = (k == 0) ? TkVar : (k == 1) ? TkFunction : TkReturn;
      end
    end
    return kind;
  endfunction

endpackage

// ----- rtl/stt_front.sv -----
// Scanner front: takes one character per cycle unless the queue is full,
// updates scan state and builds the tokens it causes. Depends on stt_pkg.
module stt_front #(
  parameter int OFFSET_BITS = stt_pkg::OffsetBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stt_pkg::in_item_t in_item_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output stt_pkg::bundle_t  push_data_o
);

  localparam int W = OFFSET_BITS;

  stt_pkg::scan_mode_e mode_q, mode_d;
  logic [W-1:0]        pos_q, pos_d, beg_q, beg_d;
  stt_pkg::kw_state_t  kw_q, kw_d;
  logic                accept;
  logic [W-1:0]        end_pos;
  logic [7:0]          c;
  logic                used;
  logic [1:0]          n;
  stt_pkg::bundle_t    bnd;

  function automatic logic [15:0] clip16(logic [W-1:0] v);
    logic [W+15:0] ext;
    ext = {16'h0, v};
    return (|(ext >> 16)) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic stt_pkg::tok_t mk_tok(logic [3:0] kind, logic [W-1:0] start,
                                           logic [W-1:0] len);
    stt_pkg::tok_t t;
    t.token_kind   = kind;
    t.token_start  = clip16(start);
    t.token_length = clip16(len);
    return t;
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = full_i;
  assign c          = in_item_i.char_code;
  assign end_pos    = (pos_q == {W{1'b1}}) ? pos_q : pos_q + W'(1);

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    beg_d  = beg_q;
    kw_d   = kw_q;
    used   = 1'b0;
    n      = 2'd0;
    bnd    = '0;
    if (mode_q == stt_pkg::ModeError) begin
      if (in_item_i.last_char) begin
        mode_d = stt_pkg::ModeIdle;
        pos_d  = '0;
        beg_d  = '0;
        kw_d   = '{cand: 3'b111, idx: 4'd0};
      end else begin
        pos_d = end_pos;
      end
    end else begin
      unique case (mode_q)
        stt_pkg::ModeIdent: begin
          if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
            kw_d = stt_pkg::kw_advance(kw_q, c);
            used = 1'b1;
          end else begin
            bnd.tok[n] = mk_tok(stt_pkg::ident_kind(kw_q), beg_q, pos_q - beg_q);
            n          = n + 2'd1;
            mode_d     = stt_pkg::ModeIdle;
          end
        end
        stt_pkg::ModeInt: begin
          if (stt_pkg::is_digit(c)) begin
            used = 1'b1;
          end else begin
            bnd.tok[n] = mk_tok(stt_pkg::TkInteger, beg_q, pos_q - beg_q);
            n          = n + 2'd1;
            mode_d     = stt_pkg::ModeIdle;
          end
        end
        stt_pkg::ModeComment: begin
          used = 1'b1;
          if (c == stt_pkg::CharLf) begin
            mode_d = stt_pkg::ModeIdle;
          end
        end
        stt_pkg::ModeIdle, stt_pkg::ModeError: begin
        end
        default: begin
        end
      endcase

      // The ending character is scanned as if idle
      if (!used && mode_d == stt_pkg::ModeIdle) begin
        priority if (stt_pkg::is_space(c)) begin
        end else if (c == stt_pkg::CharSemi) begin
          mode_d = stt_pkg::ModeComment;
        end else if (c == stt_pkg::CharLParen) begin
          bnd.tok[n] = mk_tok(stt_pkg::TkLParen, pos_q, W'(1));
          n          = n + 2'd1;
        end else if (c == stt_pkg::CharRParen) begin
          bnd.tok[n] = mk_tok(stt_pkg::TkRParen, pos_q, W'(1));
          n          = n + 2'd1;
        end else if (stt_pkg::is_letter(c)) begin
          mode_d = stt_pkg::ModeIdent;
          beg_d  = pos_q;
          kw_d   = stt_pkg::kw_advance('{cand: 3'b111, idx: 4'd0}, c);
        end else if (stt_pkg::is_digit(c)) begin
          mode_d = stt_pkg::ModeInt;
          beg_d  = pos_q;
        end else begin
          bnd.tok[n] = mk_tok(stt_pkg::TkError, pos_q, W'(1));
          n          = n + 2'd1;
          mode_d     = stt_pkg::ModeError;
        end
      end

      if (in_item_i.last_char) begin
        if (mode_d == stt_pkg::ModeIdent) begin
          bnd.tok[n] = mk_tok(stt_pkg::ident_kind(kw_d), beg_d, end_pos - beg_d);
          n          = n + 2'd1;
        end else if (mode_d == stt_pkg::ModeInt) begin
          bnd.tok[n] = mk_tok(stt_pkg::TkInteger, beg_d, end_pos - beg_d);
          n          = n + 2'd1;
        end
        if (mode_d != stt_pkg::ModeError) begin
          bnd.tok[n] = mk_tok(stt_pkg::TkEof, end_pos, '0);
          n          = n + 2'd1;
        end
        // Start a new source
        mode_d = stt_pkg::ModeIdle;
        pos_d  = '0;
        beg_d  = '0;
        kw_d   = '{cand: 3'b111, idx: 4'd0};
      end else begin
        pos_d = end_pos;
      end
    end
    bnd.cnt = n;
  end

  assign push_o      = accept && (n != 2'd0);
  assign push_data_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::ModeIdle;
      pos_q  <= '0;
      beg_q  <= '0;
      kw_q   <= '{cand: 3'b111, idx: 4'd0};
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      beg_q  <= beg_d;
      kw_q   <= kw_d;
    end
  end

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_q == stt_pkg::ModeError |-> !push_o)
    else $error("tokens pushed while skipping after an error");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.last_char |=> mode_q == stt_pkg::ModeIdle && pos_q == '0)
    else $error("scan state not cleared after last character");

endmodule

// ----- rtl/stt_queue.sv -----
// Small FIFO of token groups between the scanner and the token serializer.
// Depends on stt_pkg.
module stt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output stt_pkg::bundle_t head_o
);

  localparam int Depth = stt_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  stt_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ----- rtl/stt_back.sv -----
// Token serializer: walks the head token group one token per cycle into the
// output register while the output is not stalled. Depends on stt_pkg.
module stt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  stt_pkg::bundle_t   q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output stt_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);

  logic                mid_group;
  logic [1:0]          idx;
  logic                adv, take, is_last;
  logic [1:0]          sel_q;
  stt_pkg::out_item_t  out_q;
  logic                out_valid_q;

  assign idx     = sel_q;
  assign adv     = !out_valid_q || !out_stall_i;
  assign take    = adv && q_valid_i;
  assign is_last = (idx == q_item_i.cnt - 2'd1);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= q_valid_i;
      if (q_valid_i) begin
        sel_q <= is_last ? 2'd0 : sel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.token_kind   <= q_item_i.tok[idx].token_kind;
      out_q.token_start  <= q_item_i.tok[idx].token_start;
      out_q.token_length <= q_item_i.tok[idx].token_length;
      out_q.last_result  <= is_last;
    end
  end

  // Marks that a group is partway through
  assign mid_group = (sel_q != 2'd0);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> q_item_i.cnt != 2'd0)
    else $error("empty token group in queue");

  a_index_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_group |-> q_valid_i && sel_q < q_item_i.cnt)
    else $error("token index outside the head group");

endmodule

// ----- rtl/source_text_tokenizer.sv -----
// Source text tokenizer: accepts one character per cycle; each character causes
// zero to three tokens, which leave one per cycle from a registered output, the
// last token of a character marked by last_result. A four-entry queue of token
// groups sits between the scanner and the output serializer, so the input
// stalls only once that queue is full, i.e. when tokens are produced faster than
// one per cycle on average or the output side stalls. A character's tokens pass
// through a queue entry and then the output register. There is no clearing pass
// after reset.
module source_text_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OffsetBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stt_pkg::out_item_t out_item_o
);

  logic             push, full, pop, q_valid;
  stt_pkg::bundle_t push_data, q_head;

  stt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_data_o(push_data)
  );

  stt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  stt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule
